@@ rtl/ita_pkg.sv @@
package ita_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned OpW   = 2;
  localparam int unsigned BinW  = 32;
  localparam int unsigned ByteW = 8;

  // Decimal conversion: ten BCD digits cover the full 32-bit range.
  localparam int unsigned DigW      = 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = NumDigits * DigW;
  localparam int unsigned IdxW      = $clog2(NumDigits);
  localparam int unsigned CntW      = $clog2(BinW);

  // Depth of the queue between front and back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // ASCII codes.
  localparam logic [ByteW-1:0] CharZero  = 8'h30;
  localparam logic [ByteW-1:0] CharMinus = 8'h2D;
  localparam logic [ByteW-1:0] CharLowA  = 8'h61;
  localparam logic [ByteW-1:0] CharUpA   = 8'h41;
  localparam logic [ByteW-1:0] DecBase   = 8'd10;

  typedef enum logic [OpW-1:0] {
    OP_SDEC = 2'd0,
    OP_UDEC = 2'd1,
    OP_LHEX = 2'd2,
    OP_UHEX = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]  operation;
    logic [BinW-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [ByteW-1:0] character;
    logic             last;
  } out_word_t;

  // One classified job as it waits in the queue.
  typedef struct packed {
    logic            neg;
    logic            dec;
    logic            upper;
    logic [BinW-1:0] mag;
  } job_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Maps one digit (0 to 15) to its ASCII code.
  function automatic logic [ByteW-1:0] digit_char(input logic [DigW-1:0] d,
                                                  input logic upper);
    logic [ByteW-1:0] dw;
    dw = {{(ByteW-DigW){1'b0}}, d};
    if (dw < DecBase) begin
      return CharZero + dw;
    end else if (upper) begin
      return CharUpA + dw - DecBase;
    end else begin
      return CharLowA + dw - DecBase;
    end
  endfunction

endpackage

@@ rtl/ita_fifo.sv @@
module ita_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ita_pkg::job_t       push_data_i,
  input  logic                pop_i,
  output ita_pkg::job_t       pop_data_o,
  output ita_pkg::q_status_t  status_o
);

  ita_pkg::job_t                 mem_q [ita_pkg::QDepth];
  logic [ita_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [ita_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [ita_pkg::QCntW-1:0]     cnt_q, cnt_d;

  localparam logic [ita_pkg::QPtrW-1:0] PtrLast = ita_pkg::QPtrW'(ita_pkg::QDepth - 1);
  localparam logic [ita_pkg::QCntW-1:0] CntFull = ita_pkg::QCntW'(ita_pkg::QDepth);

  assign status_o.full  = (cnt_q == CntFull);
  assign status_o.empty = (cnt_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + ita_pkg::QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + ita_pkg::QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + ita_pkg::QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - ita_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/ita_front.sv @@
module ita_front (
  input  logic                in_valid_i,
  input  ita_pkg::in_word_t   in_word_i,
  output logic                in_stall_o,
  input  ita_pkg::q_status_t  q_status_i,
  output logic                push_o,
  output ita_pkg::job_t       job_o
);

  logic neg;

  // A word is taken whenever the queue has room.
  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  // Classify the word: sign, magnitude and output radix.
  assign neg = (in_word_i.operation == ita_pkg::OP_SDEC) && in_word_i.value[ita_pkg::BinW-1];

  always_comb begin
    job_o.neg   = neg;
    job_o.dec   = (in_word_i.operation == ita_pkg::OP_SDEC) ||
                  (in_word_i.operation == ita_pkg::OP_UDEC);
    job_o.upper = (in_word_i.operation == ita_pkg::OP_UHEX);
    job_o.mag   = neg ? (ita_pkg::BinW'(0) - in_word_i.value) : in_word_i.value;
  end

endmodule

@@ rtl/ita_back.sv @@
module ita_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ita_pkg::job_t       job_i,
  input  ita_pkg::q_status_t  q_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ita_pkg::out_word_t  out_word_o
);

  localparam logic [ita_pkg::CntW-1:0] CntLast = ita_pkg::CntW'(ita_pkg::BinW - 1);
  localparam logic [ita_pkg::DigW-1:0] AdjLim  = 4'd5;
  localparam logic [ita_pkg::DigW-1:0] AdjAdd  = 4'd3;

  ita_pkg::state_e               state_q, state_d;
  logic                          out_valid_q, out_valid_d;
  ita_pkg::out_word_t            out_word_q;
  logic [ita_pkg::BinW-1:0]      bin_q;
  logic [ita_pkg::BcdW-1:0]      bcd_q, bcd_adj;
  logic [ita_pkg::CntW-1:0]      cnt_q;
  logic [ita_pkg::IdxW-1:0]      idx_q, top_idx;
  logic                          neg_q;
  logic                          upper_q;

  logic                          out_free;
  logic                          emit;
  logic                          emit_last;
  logic [ita_pkg::ByteW-1:0]     emit_char;

  // Double-dabble correction: add three to every digit of five or more.
  always_comb begin
    logic [ita_pkg::DigW-1:0] d;
    for (int i = 0; i < ita_pkg::NumDigits; i++) begin
      d = bcd_q[i*ita_pkg::DigW +: ita_pkg::DigW];
      bcd_adj[i*ita_pkg::DigW +: ita_pkg::DigW] = (d >= AdjLim) ? d + AdjAdd : d;
    end
  end

  // Position of the most significant nonzero digit, zero if all are zero.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < ita_pkg::NumDigits; i++) begin
      if (bcd_q[i*ita_pkg::DigW +: ita_pkg::DigW] != '0) begin
        top_idx = ita_pkg::IdxW'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ita_pkg::ST_IDLE: begin
        if (!q_status_i.empty) begin
          state_d = job_i.dec ? ita_pkg::ST_CONV : ita_pkg::ST_SCAN;
        end
      end
      ita_pkg::ST_CONV: begin
        if (cnt_q == CntLast) begin
          state_d = ita_pkg::ST_SCAN;
        end
      end
      ita_pkg::ST_SCAN: begin
        state_d = ita_pkg::ST_EMIT;
      end
      ita_pkg::ST_EMIT: begin
        if (emit && emit_last) begin
          state_d = ita_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ita_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    out_free  = !out_valid_q || !out_stall_i;
    pop_o     = (state_q == ita_pkg::ST_IDLE) && !q_status_i.empty;
    emit      = (state_q == ita_pkg::ST_EMIT) && out_free;
    emit_last = !neg_q && (idx_q == '0);
    emit_char = neg_q ? ita_pkg::CharMinus
                      : ita_pkg::digit_char(bcd_q[idx_q*ita_pkg::DigW +: ita_pkg::DigW],
                                            upper_q);
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ita_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath: load, shift-and-add conversion, digit walk and output word.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      neg_q   <= job_i.neg;
      upper_q <= job_i.upper;
      bin_q   <= job_i.mag;
      cnt_q   <= '0;
      bcd_q   <= job_i.dec ? '0 : {{(ita_pkg::BcdW-ita_pkg::BinW){1'b0}}, job_i.mag};
    end else if (state_q == ita_pkg::ST_CONV) begin
      bcd_q <= {bcd_adj[ita_pkg::BcdW-2:0], bin_q[ita_pkg::BinW-1]};
      bin_q <= {bin_q[ita_pkg::BinW-2:0], 1'b0};
      cnt_q <= cnt_q + ita_pkg::CntW'(1);
    end
    if (state_q == ita_pkg::ST_SCAN) begin
      idx_q <= top_idx;
    end else if (emit) begin
      if (neg_q) begin
        neg_q <= 1'b0;
      end else if (idx_q != '0) begin
        idx_q <= idx_q - ita_pkg::IdxW'(1);
      end
    end
    if (emit) begin
      out_word_q.character <= emit_char;
      out_word_q.last      <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ rtl/integer_to_ascii_formatter.sv @@
// A decimal word passes through the queue pop, the shift-and-add conversion, the digit scan and
// the output register on its way to the first character; a hex word skips the conversion.
// Characters leave at one a cycle while the receiver does not stall; the rate of words is
// bounded by the bit-serial shift-and-add converter, which works on decimal words only.
// A two-word queue lets new words be taken while the converter is busy.
// Reset is asynchronous and active low; it empties the queue and drops any pending output.
module integer_to_ascii_formatter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ita_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ita_pkg::out_word_t  out_word_o
);

  logic                push;
  logic                pop;
  ita_pkg::job_t       push_job;
  ita_pkg::job_t       pop_job;
  ita_pkg::q_status_t  q_status;

  // Classification of incoming words.
  ita_front u_front (
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_stall_o (in_stall_o),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (push_job)
  );

  // Queue between the two halves.
  ita_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .status_o    (q_status)
  );

  // Conversion and character output.
  ita_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

@@ rtl/ita_checker.sv @@
module ita_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input ita_pkg::in_word_t   in_word_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ita_pkg::out_word_t  out_word_o
);

  logic [ita_pkg::ByteW-1:0] c;
  logic                      is_minus;
  logic                      is_nonzero_digit;
  logic                      unused_in;

  assign c                = out_word_o.character;
  assign is_minus         = (c == ita_pkg::CharMinus);
  assign is_nonzero_digit = (c >= 8'h31) && (c <= 8'h39);
  assign unused_in        = in_valid_i ^ in_stall_o ^ (^in_word_i);

  // A stalled output word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // Only digits, hex letters and the minus sign are produced.
  a_out_charset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
                    (c >= 8'h41 && c <= 8'h46) || is_minus)
    else $error("unexpected character code");

  // A minus sign never ends a text.
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_minus |-> !out_word_o.last)
    else $error("minus sign marked as last");

  // The character after a minus sign follows at once and is a nonzero digit.
  a_minus_then_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && is_minus |=> out_valid_o && is_nonzero_digit)
    else $error("minus sign not followed by a leading digit");

endmodule

bind integer_to_ascii_formatter ita_checker u_checker (.*);

@@ verif/ita_checker.sv @@
module ita_scoreboard (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  ita_pkg::in_word_t   in_word_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  ita_pkg::out_word_t  out_word_i,
  output int                  errors_o,
  output int                  pending_o
);

  // Characters still owed by the block, oldest first.
  ita_pkg::out_word_t owed_chars[$];
  int                 fail_count = 0;

  logic [10:0][ita_pkg::ByteW-1:0] text;
  int                              text_len;
  ita_pkg::out_word_t              want;

  // Renders a value as ASCII text, most significant character first.
  // Returns the number of characters written to text.
  function automatic int render_text(input logic [ita_pkg::OpW-1:0] op,
                                     input logic [ita_pkg::BinW-1:0] value,
                                     output logic [10:0][ita_pkg::ByteW-1:0] text);
    logic [ita_pkg::BinW-1:0]       mag;
    logic [ita_pkg::BinW-1:0]       rem;
    logic [9:0][ita_pkg::ByteW-1:0] rev;
    logic [ita_pkg::DigW-1:0]       nib;
    logic                           neg;
    logic                           dec;
    logic                           more;
    int                             nd;
    int                             len;
    int                             lim;
    neg  = (op == ita_pkg::OP_SDEC) && value[ita_pkg::BinW-1];
    dec  = (op == ita_pkg::OP_SDEC) || (op == ita_pkg::OP_UDEC);
    mag  = neg ? (32'd0 - value) : value;
    lim  = dec ? 10 : 8;
    rev  = '0;
    text = '0;
    nd   = 0;
    more = 1'b1;
    // Peel digits off the low end until nothing is left.
    while (more) begin
      if (dec) begin
        rem = mag % 32'd10;
        nib = rem[ita_pkg::DigW-1:0];
        mag = mag / 32'd10;
      end else begin
        nib = mag[ita_pkg::DigW-1:0];
        mag = mag >> ita_pkg::DigW;
      end
      if (nib < 4'd10) begin
        rev[nd] = ita_pkg::CharZero + {4'b0000, nib};
      end else if (op == ita_pkg::OP_UHEX) begin
        rev[nd] = ita_pkg::CharUpA + {4'b0000, nib} - 8'd10;
      end else begin
        rev[nd] = ita_pkg::CharLowA + {4'b0000, nib} - 8'd10;
      end
      nd++;
      more = (mag != '0) && (nd < lim);
    end
    len = 0;
    if (neg) begin
      text[len] = ita_pkg::CharMinus;
      len++;
    end
    while (nd > 0) begin
      nd--;
      text[len] = rev[nd];
      len++;
    end
    return len;
  endfunction

  // Compare outgoing words, then queue the text of an incoming word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (owed_chars.size() == 0) begin
          $error("unexpected output word: character %h last %b",
                 out_word_i.character, out_word_i.last);
          fail_count++;
        end else begin
          want = owed_chars.pop_front();
          if (out_word_i.character !== want.character) begin
            $error("character: expected %h, actual %h", want.character,
                   out_word_i.character);
            fail_count++;
          end
          if (out_word_i.last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, out_word_i.last);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        text_len = render_text(in_word_i.operation, in_word_i.value, text);
        for (int k = 0; k < text_len; k++) begin
          want.character = text[k];
          want.last      = (k == text_len - 1);
          owed_chars.push_back(want);
        end
      end
      errors_o  <= fail_count;
      pending_o <= owed_chars.size();
    end
  end

endmodule

@@ verif/tb_integer_to_ascii_formatter.sv @@
module tb_integer_to_ascii_formatter;

  localparam int unsigned RandomItems = 480;
  localparam int unsigned IdlePct     = 29;
  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned TailCycles  = 60;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  ita_pkg::in_word_t  in_word   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  ita_pkg::out_word_t out_word;
  int                 errors;
  int                 pending;
  int                 quiet_cycles = 0;
  logic               calm = 1'b0;

  integer_to_ascii_formatter DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  ita_scoreboard u_scoreboard (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at random, except during the calm stretch.
  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IdlePct);
  end

  // Watchdog: too long without any word moving on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offers one word, with random idle cycles ahead of it, and waits until taken.
  task automatic send_word(input ita_pkg::op_e op, input logic [ita_pkg::BinW-1:0] value);
    ita_pkg::in_word_t w;
    w.operation = op;
    w.value     = value;
    while (!calm && ($urandom_range(0, 99) < IdlePct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Holds the input off until every owed character has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [ita_pkg::BinW-1:0] value;
    logic [ita_pkg::BinW-1:0] p;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero, all ones and the most negative value in every mode.
    for (int m = 0; m < 4; m++) begin
      send_word(ita_pkg::op_e'(m), 32'h0000_0000);
      send_word(ita_pkg::op_e'(m), 32'hFFFF_FFFF);
      send_word(ita_pkg::op_e'(m), 32'h8000_0000);
    end
    // Digit boundaries, letters and small negatives.
    send_word(ita_pkg::OP_SDEC, 32'h7FFF_FFFF);
    send_word(ita_pkg::OP_SDEC, 32'h0000_0001);
    send_word(ita_pkg::OP_SDEC, 32'hFFFF_FFF6);
    send_word(ita_pkg::OP_UDEC, 32'd9);
    send_word(ita_pkg::OP_UDEC, 32'd10);
    send_word(ita_pkg::OP_UDEC, 32'd1000000000);
    send_word(ita_pkg::OP_LHEX, 32'hDEAD_BEEF);
    send_word(ita_pkg::OP_UHEX, 32'hDEAD_BEEF);
    send_word(ita_pkg::OP_LHEX, 32'h0000_000F);
    send_word(ita_pkg::OP_UHEX, 32'h0000_0010);
    send_word(ita_pkg::OP_LHEX, 32'h89AB_CDEF);
    wait_drained();

    // Random words of every length.
    for (int i = 0; i < RandomItems; i++) begin
      calm = (i >= 200) && (i < 300);
      if (i == 120 || i == 380) begin
        wait_drained();
      end
      case ($urandom_range(0, 5))
        0: value = $urandom();
        1: value = $urandom() >> $urandom_range(0, 31);
        2: value = $urandom_range(0, 20);
        3: begin
          p = 32'd1;
          repeat ($urandom_range(0, 9)) p = p * 32'd10;
          value = p + $urandom_range(0, 2) - 32'd1;
        end
        4: value = ($urandom_range(0, 1) ? 32'h7FFF_FFFC : 32'hFFFF_FFFC) +
                   $urandom_range(0, 7);
        default: value = ~($urandom() >> $urandom_range(0, 31));
      endcase
      send_word(ita_pkg::op_e'($urandom_range(0, 3)), value);
    end
    calm = 1'b0;
    wait_drained();
    repeat (TailCycles) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
